[rtl/iir_q15_pkg.sv]
// ----------------------------------------------------------------------------
// iir_q15_pkg
// Shared types and constants of the direct-form-I Q15 IIR filter.
// ----------------------------------------------------------------------------
`default_nettype none

package iir_q15_pkg;

  localparam int SampleW = 16;
  localparam int FfTaps  = 3;
  localparam int FbTaps  = 4;
  localparam int NumRegs = FfTaps + FbTaps;
  localparam int IdxW    = 3;
  // each product contributes bits [31:15], the sum of seven needs three more
  localparam int TermW   = 2 * SampleW - (SampleW - 1);
  localparam int AccW    = TermW + 3;

  typedef logic signed [SampleW-1:0] q15_t;
  typedef logic [IdxW-1:0] reg_idx_t;

  // coefficient register indexes
  localparam reg_idx_t RegFfCoef1 = 3'd0;
  localparam reg_idx_t RegFfCoef2 = 3'd1;
  localparam reg_idx_t RegFfCoef3 = 3'd2;
  localparam reg_idx_t RegFbCoef1 = 3'd3;
  localparam reg_idx_t RegFbCoef2 = 3'd4;
  localparam reg_idx_t RegFbCoef3 = 3'd5;
  localparam reg_idx_t RegFbCoef4 = 3'd6;

  localparam q15_t FfCoef1Reset = 16'sd322;
  localparam q15_t FfCoef2Reset = 16'sd0;
  localparam q15_t FfCoef3Reset = 16'sd0;
  localparam q15_t FbCoef1Reset = 16'sd30003;
  localparam q15_t FbCoef2Reset = -16'sd29448;
  localparam q15_t FbCoef3Reset = 16'sd0;
  localparam q15_t FbCoef4Reset = 16'sd0;

  typedef struct packed {
    q15_t [FfTaps-1:0] ff;
    q15_t [FbTaps-1:0] fb;
  } coef_set_t;

  // delay lines, element 0 is the newest
  typedef q15_t [FfTaps-1:0] x_hist_t;
  typedef q15_t [FbTaps-1:0] y_hist_t;

endpackage

`default_nettype wire

[rtl/iir_q15_regs.sv]
// ----------------------------------------------------------------------------
// iir_q15_regs
// Coefficient register file written through the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_q15_regs
  import iir_q15_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire reg_idx_t  cfg_index,
  input  wire q15_t      cfg_data,
  output coef_set_t      coef
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.ff[0] <= FfCoef1Reset;
      coef.ff[1] <= FfCoef2Reset;
      coef.ff[2] <= FfCoef3Reset;
      coef.fb[0] <= FbCoef1Reset;
      coef.fb[1] <= FbCoef2Reset;
      coef.fb[2] <= FbCoef3Reset;
      coef.fb[3] <= FbCoef4Reset;
    end else if (cfg_valid) begin
      // indexes past the last register are dropped
      unique case (cfg_index)
        RegFfCoef1: coef.ff[0] <= cfg_data;
        RegFfCoef2: coef.ff[1] <= cfg_data;
        RegFfCoef3: coef.ff[2] <= cfg_data;
        RegFbCoef1: coef.fb[0] <= cfg_data;
        RegFbCoef2: coef.fb[1] <= cfg_data;
        RegFbCoef3: coef.fb[2] <= cfg_data;
        RegFbCoef4: coef.fb[3] <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/iir_q15_mac.sv]
// ----------------------------------------------------------------------------
// iir_q15_mac
// Seven parallel Q15 products, adder and saturation to sixteen bits.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_q15_mac
  import iir_q15_pkg::*;
(
  input  wire x_hist_t   x_hist,
  input  wire y_hist_t   y_hist,
  input  wire coef_set_t coef,
  output q15_t           y
);

  localparam logic signed [AccW-1:0] AccMax = AccW'(32767);
  localparam logic signed [AccW-1:0] AccMin = -AccW'(32768);

  logic signed [2*SampleW-1:0] prod_ff [FfTaps];
  logic signed [2*SampleW-1:0] prod_fb [FbTaps];
  logic signed [AccW-1:0]      acc;

  always_comb begin
    for (int i = 0; i < FfTaps; i++) begin
      prod_ff[i] = $signed(x_hist[i]) * $signed(coef.ff[i]);
    end
    for (int i = 0; i < FbTaps; i++) begin
      prod_fb[i] = $signed(y_hist[i]) * $signed(coef.fb[i]);
    end
  end

  // dropping the low 15 bits is a floor shift; min*min stays +32768 here
  always_comb begin
    acc = '0;
    for (int i = 0; i < FfTaps; i++) begin
      acc = acc + AccW'($signed(prod_ff[i][2*SampleW-1:SampleW-1]));
    end
    for (int i = 0; i < FbTaps; i++) begin
      acc = acc + AccW'($signed(prod_fb[i][2*SampleW-1:SampleW-1]));
    end
  end

  always_comb begin
    if (acc > AccMax) begin
      y = 16'sh7fff;
    end else if (acc < AccMin) begin
      y = -16'sh8000;
    end else begin
      y = acc[SampleW-1:0];
    end
  end

endmodule

`default_nettype wire

[rtl/iir_filter_q15.sv]
// ----------------------------------------------------------------------------
// iir_filter_q15
// Direct-form-I IIR filter on signed Q15 samples with programmable taps.
// ----------------------------------------------------------------------------
// Each input word yields one output word. The output is built from the three
// previous inputs and the four previous outputs only, so the word just taken
// waits in an input register and enters the input delay line when its output
// is computed. One word is taken per clock while the output side keeps up; a
// word passes through the input register and then the output register, around
// the single multiply-accumulate pass. The coefficients come up at their
// reset values and may be rewritten through the cfg channel while no word is
// in flight; indexes past the seventh register are ignored.
`default_nettype none

module iir_filter_q15
  import iir_q15_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] sample_in
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [15:0] sample_out
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  coef_set_t coef;
  logic      in_valid;
  q15_t      in_sample;
  x_hist_t   x_hist;
  y_hist_t   y_hist;
  q15_t      y;
  logic      advance;

  iir_q15_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  iir_q15_mac u_mac (
    .x_hist (x_hist),
    .y_hist (y_hist),
    .coef   (coef),
    .y      (y)
  );

  // held word moves on when the output register is free or draining
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      x_hist        <= '0;
      y_hist        <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        m_axis_tvalid <= 1'b1;
        x_hist        <= {x_hist[FfTaps-2:0], in_sample};
        y_hist        <= {y_hist[FbTaps-2:0], y};
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_sample <= s_axis_tdata;
    end
    if (advance) begin
      m_axis_tdata <= y;
    end
  end

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Q15 direct-form-I IIR filter.
// ----------------------------------------------------------------------------
// Sends sample words in and checks every output word against a filter model
// kept in this bench. The model has its own coefficient copy and delay lines.
// A short directed table covers the reset taps, products of two minimum
// values, saturation both ways and the write to the unused register index.
// After that come random phases, each with its own coefficient set. Both
// stream sides stall at random, and coefficients are only written while the
// filter is empty.
`default_nettype none

module tb
  import iir_q15_pkg::*;
;

  localparam reg_idx_t RegUnused = 3'd7;   // past the last tap, write dropped
  localparam int DrainSlack = 4;           // input and output registers plus margin
  localparam int PhaseCount = 8;
  localparam int PhaseItems = 200;
  localparam int ErrPrintMax = 20;

  typedef enum logic {RowSample, RowCoef} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    reg_idx_t  idx;
    q15_t      value;
    logic      fixed;    // expected output typed in the table
    q15_t      want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;     // [15:0] sample_in
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;     // [15:0] sample_out
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  // filter model state
  q15_t coef   [NumRegs];
  q15_t x_hist [FfTaps];
  q15_t y_hist [FbTaps];

  q15_t      out_q [$];
  stim_row_t dir_rows [$];
  q15_t      head_word;
  int        err_count;
  int        samples_sent;
  int        outputs_checked;
  int        coef_sets;
  bit        tx_quiet;
  bit        rx_quiet;

  iir_filter_q15 i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_error(input string msg);
    err_count++;
    if (err_count <= ErrPrintMax) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end else if (r < 95) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(8, 40);
    end
  endfunction

  function automatic q15_t pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      return 16'sh7fff;
    end else if (r < 12) begin
      return 16'sh8000;
    end else if (r < 30) begin
      return q15_t'(int'($urandom_range(0, 511)) - 256);
    end else begin
      return q15_t'($urandom);
    end
  endfunction

  // floor of the Q15 product; min times min gives +32768, kept unclamped
  function automatic int q15_product(input q15_t a, input q15_t b);
    int p;
    p = int'(a) * int'(b);
    return p >>> 15;
  endfunction

  function automatic q15_t filter_next(input q15_t x);
    int   acc;
    q15_t y;
    acc = 0;
    for (int i = 0; i < FfTaps; i++) begin
      acc += q15_product(x_hist[i], coef[i]);
    end
    for (int i = 0; i < FbTaps; i++) begin
      acc += q15_product(y_hist[i], coef[FfTaps + i]);
    end
    if (acc > 32767) begin
      y = 16'sh7fff;
    end else if (acc < -32768) begin
      y = 16'sh8000;
    end else begin
      y = q15_t'(acc);
    end
    for (int i = FfTaps - 1; i > 0; i--) begin
      x_hist[i] = x_hist[i - 1];
    end
    x_hist[0] = x;
    for (int i = FbTaps - 1; i > 0; i--) begin
      y_hist[i] = y_hist[i - 1];
    end
    y_hist[0] = y;
    return y;
  endfunction

  task automatic add_sample(input q15_t v, input logic fixed, input q15_t want);
    stim_row_t row;
    row.kind  = RowSample;
    row.idx   = RegFfCoef1;
    row.value = v;
    row.fixed = fixed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  task automatic add_coef(input reg_idx_t idx, input q15_t v);
    stim_row_t row;
    row.kind  = RowCoef;
    row.idx   = idx;
    row.value = v;
    row.fixed = 1'b0;
    row.want  = '0;
    dir_rows.push_back(row);
  endtask

  // called at a falling edge, returns at the falling edge after the handshake
  task automatic send_sample(input q15_t x, input logic fixed, input q15_t want);
    q15_t y;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    do @(posedge clk); while (!s_axis_tready);
    y = filter_next(x);
    out_q.push_back(fixed ? want : y);
    samples_sent++;
    @(negedge clk);
  endtask

  // leaves cfg_valid high, the caller drops it after the last write
  task automatic write_reg(input reg_idx_t idx, input q15_t v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NumRegs) begin
      coef[idx] = v;
    end
    @(negedge clk);
  endtask

  task automatic sender_gap();
    int gap;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain_filter();
    s_axis_tvalid <= 1'b0;
    while (out_q.size() != 0) @(negedge clk);
    repeat (DrainSlack) @(negedge clk);
  endtask

  // output side: random backpressure
  initial begin
    int stall;
    stall = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!rx_quiet) begin
          stall = pick_gap();
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (out_q.size() == 0) begin
        report_error($sformatf("output word %0d with none pending",
                               $signed(m_axis_tdata)));
      end else begin
        head_word = out_q.pop_front();
        outputs_checked++;
        if (m_axis_tdata !== head_word) begin
          report_error($sformatf("sample_out got %0d want %0d",
                                 $signed(m_axis_tdata), head_word));
        end
      end
    end
  end

  initial begin
    q15_t set_vals [NumRegs];
    int   w;

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    tx_quiet      = 1'b0;
    rx_quiet      = 1'b0;
    err_count       = 0;
    samples_sent    = 0;
    outputs_checked = 0;
    coef_sets       = 1;

    coef[RegFfCoef1] = FfCoef1Reset;
    coef[RegFfCoef2] = FfCoef2Reset;
    coef[RegFfCoef3] = FfCoef3Reset;
    coef[RegFbCoef1] = FbCoef1Reset;
    coef[RegFbCoef2] = FbCoef2Reset;
    coef[RegFbCoef3] = FbCoef3Reset;
    coef[RegFbCoef4] = FbCoef4Reset;
    foreach (x_hist[i]) x_hist[i] = '0;
    foreach (y_hist[i]) y_hist[i] = '0;

    // reset taps, empty delay lines give zero first
    add_sample(16'sh7fff, 1'b1, 16'sh0000);
    add_sample(16'sh8000, 1'b0, '0);
    add_sample(16'sh0001, 1'b0, '0);
    add_sample(16'shffff, 1'b0, '0);
    // single feed-forward tap at minimum, stray index write dropped
    add_coef(RegFfCoef1, 16'sh8000);
    add_coef(RegFfCoef2, 16'sh0000);
    add_coef(RegFfCoef3, 16'sh0000);
    add_coef(RegFbCoef1, 16'sh0000);
    add_coef(RegUnused,  16'sh7fff);
    add_coef(RegFbCoef2, 16'sh0000);
    add_coef(RegFbCoef3, 16'sh0000);
    add_coef(RegFbCoef4, 16'sh0000);
    add_sample(16'sh0000, 1'b0, '0);
    add_sample(16'sh8000, 1'b1, 16'sh0000);
    add_sample(16'sh7fff, 1'b1, 16'sh7fff);   // min times min, clamped
    add_sample(16'sh8000, 1'b1, -16'sd32767);
    add_sample(16'sh0000, 1'b1, 16'sh7fff);
    // all taps at maximum
    add_coef(RegFfCoef1, 16'sh7fff);
    add_coef(RegFfCoef2, 16'sh7fff);
    add_coef(RegFfCoef3, 16'sh7fff);
    add_coef(RegFbCoef1, 16'sh7fff);
    add_coef(RegFbCoef2, 16'sh7fff);
    add_coef(RegFbCoef3, 16'sh7fff);
    add_coef(RegFbCoef4, 16'sh7fff);
    repeat (4) add_sample(16'sh7fff, 1'b0, '0);
    // all taps at minimum
    add_coef(RegFfCoef1, 16'sh8000);
    add_coef(RegFfCoef2, 16'sh8000);
    add_coef(RegFfCoef3, 16'sh8000);
    add_coef(RegFbCoef1, 16'sh8000);
    add_coef(RegFbCoef2, 16'sh8000);
    add_coef(RegFbCoef3, 16'sh8000);
    add_coef(RegFbCoef4, 16'sh8000);
    add_sample(16'sh8000, 1'b0, '0);
    add_sample(16'sh8000, 1'b0, '0);
    add_sample(16'sh7fff, 1'b0, '0);
    add_sample(16'sh7fff, 1'b0, '0);
    add_sample(16'sh0000, 1'b0, '0);
    // mixed signs
    add_coef(RegFfCoef1, 16'sd16384);
    add_coef(RegFfCoef2, -16'sd16384);
    add_coef(RegFfCoef3, 16'sh7fff);
    add_coef(RegFbCoef1, -16'sd1);
    add_coef(RegFbCoef2, 16'sd1);
    add_coef(RegFbCoef3, 16'sd16384);
    add_coef(RegFbCoef4, 16'sh8000);
    add_sample(16'sd12345, 1'b0, '0);
    add_sample(-16'sd12345, 1'b0, '0);
    add_sample(16'sd255, 1'b0, '0);
    add_sample(-16'sd256, 1'b0, '0);

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int r = 0; r < dir_rows.size(); r++) begin
      if (dir_rows[r].kind == RowCoef) begin
        if (!cfg_valid) begin
          drain_filter();
        end
        write_reg(dir_rows[r].idx, dir_rows[r].value);
      end else begin
        if (cfg_valid) begin
          cfg_valid <= 1'b0;
          coef_sets++;
        end
        send_sample(dir_rows[r].value, dir_rows[r].fixed, dir_rows[r].want);
        sender_gap();
      end
    end

    for (int p = 0; p < PhaseCount; p++) begin
      drain_filter();
      for (int i = 0; i < NumRegs; i++) begin
        if (p == 0) begin
          set_vals[i] = '0;
        end else if (p == 1 && i >= FfTaps) begin
          // feedback sum below one keeps this set stable
          set_vals[i] = q15_t'(int'($urandom_range(0, 16383)) - 8192);
        end else begin
          set_vals[i] = q15_t'($urandom);
        end
      end
      if (p == 0) begin
        set_vals[RegFfCoef1] = FfCoef1Reset;
        set_vals[RegFbCoef1] = FbCoef1Reset;
        set_vals[RegFbCoef2] = FbCoef2Reset;
      end
      for (int i = 0; i < NumRegs; i++) begin
        write_reg(reg_idx_t'(i), set_vals[i]);
        if ($urandom_range(0, 9) == 0) begin
          write_reg(RegUnused, q15_t'($urandom));
        end
      end
      cfg_valid <= 1'b0;
      coef_sets++;
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);

      for (int n = 0; n < PhaseItems; n++) begin
        // hold the input once until the output side has caught up
        if (p == 3 && n == PhaseItems / 2) begin
          drain_filter();
        end
        send_sample(pick_sample(), 1'b0, '0);
        sender_gap();
      end
    end

    s_axis_tvalid <= 1'b0;
    for (w = 0; w < 4000 && out_q.size() != 0; w++) @(negedge clk);
    if (out_q.size() != 0) begin
      report_error($sformatf("%0d output words never came", out_q.size()));
    end
    repeat (DrainSlack * 2) @(negedge clk);

    $display("%0d samples through %0d tap settings, %0d output words checked",
             samples_sent, coef_sets, outputs_checked);
    $display("random stalls on both sides, min and max taps, saturation both ways");
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/iir_q15_pkg.sv
rtl/iir_q15_regs.sv
rtl/iir_q15_mac.sv
rtl/iir_filter_q15.sv
tb/tb.sv
